@@ hdl/wma_pkg.sv @@
// Shared constants and types for the weighted moving average block.
`timescale 1ns / 1ps

package wma_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 8;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned USED_W   = 4;
  localparam int unsigned REG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEWEST_WEIGHT = 1'b1;

  localparam logic [REG_W-1:0] WINDOW_LENGTH_RST = 8'd5;
  localparam logic [REG_W-1:0] NEWEST_WEIGHT_RST = 8'd1;

  // Input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FILL   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SHIFT,
    ST_PUT,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_e;

endpackage

@@ hdl/wma_smp_if.sv @@
// Input channel: sample or fill beats.
`timescale 1ns / 1ps

interface wma_smp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [wma_pkg::DATA_W-1:0]    sample;

  modport source (output valid, func, sample, input ready);
  modport sink   (input valid, func, sample, output ready);
endinterface

@@ hdl/wma_res_if.sv @@
// Output channel: weighted mean result beats.
`timescale 1ns / 1ps

interface wma_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wma_pkg::DATA_W-1:0]    mean_value;
  logic        [wma_pkg::USED_W-1:0]    samples_used;

  modport source (output valid, mean_value, samples_used, input ready);
  modport sink   (input valid, mean_value, samples_used, output ready);
endinterface

@@ hdl/weighted_moving_average.sv @@
// Sample beat: shift, put, add, divide and output steps, used <= WINDOW_MAX.
// A restoring divider over the full accumulator does most of that work; zero divisor: the divide is skipped.
// Fill beat: window entries 0..WINDOW_MAX are all written, one window entry per cycle.
// One item in flight; the next beat is taken while the result still sits in the output register.
// rst_ni is asynchronous, active low: registers back to 5 / 1, fill count and entry valids
// cleared, so every window entry reads zero until written; no clearing pass.
`timescale 1ns / 1ps

module weighted_moving_average #(
  parameter int unsigned WINDOW_MAX = wma_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wma_pkg::REG_W-1:0]     cfg_data_i,
  wma_smp_if.sink                       smp_i,
  wma_res_if.source                     res_o
);

  localparam int unsigned DATA_W = wma_pkg::DATA_W;
  // Fill count, window index and step counter width (0..WINDOW_MAX)
  localparam int unsigned FC_W   = $clog2(WINDOW_MAX + 1);
  // Divisor = used + weight, at most WINDOW_MAX + 255
  localparam int unsigned DVS_W  = $clog2(WINDOW_MAX + 256);
  // Sum of past entries plus weight*sample stays below (WINDOW_MAX+255)*2^31
  localparam int unsigned ACC_W  = DATA_W + DVS_W;
  localparam int unsigned CNT_W  = $clog2(ACC_W + 1);
  localparam int unsigned DEPTH  = WINDOW_MAX + 1;

  localparam logic [FC_W-1:0] WMAX_C = FC_W'(WINDOW_MAX);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  wma_pkg::state_e state_q, state_d;

  logic [wma_pkg::REG_W-1:0] wlen_q;     // window_length
  logic [wma_pkg::REG_W-1:0] wgt_q;      // newest_weight
  logic [FC_W-1:0]           fc_q, fc_d; // fill count

  logic signed [DATA_W-1:0]  x_q, x_d;           // current sample / fill value
  logic [FC_W-1:0]           used_q, used_d;     // past samples in this mean
  logic [FC_W-1:0]           step_q, step_d;     // walk over window entries
  logic signed [ACC_W-1:0]   acc_q, acc_d;       // running sum
  logic signed [ACC_W-1:0]   prod_q, prod_d;     // weight * sample
  logic [DVS_W-1:0]          dvs_q, dvs_d;       // divisor
  logic                      neg_q, neg_d;       // sign of the quotient
  logic [ACC_W-1:0]          dvd_q, dvd_d;       // dividend, shifts into quotient
  logic [DVS_W-1:0]          rem_q, rem_d;       // partial remainder
  logic [CNT_W-1:0]          cnt_q, cnt_d;       // divider bits left
  logic signed [DATA_W-1:0]  mean_q, mean_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]      out_mean_q, out_mean_d;
  logic [wma_pkg::USED_W-1:0]    out_used_q, out_used_d;

  // Window memory: one write and one registered read per cycle.
  // Per-entry valid bits make never-written entries read as zero.
  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [DATA_W-1:0]  rd_data_q;
  logic               rd_vld_q;

  logic               mem_we;
  logic [FC_W-1:0]    mem_wa;
  logic [DATA_W-1:0]  mem_wd;
  logic               mem_re;
  logic [FC_W-1:0]    mem_ra;
  logic [DATA_W-1:0]  rd_word;

  // Fill count update for an accepted sample
  logic [FC_W-1:0]    fc_nxt;

  // Divider step
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W:0]     rem_sub;
  logic               qbit;

  logic signed [8:0]  wgt_s;

  assign rd_word = rd_vld_q ? rd_data_q : '0;
  assign wgt_s   = $signed({1'b0, wgt_q});

  always_comb begin
    if (wlen_q > 8'(fc_q)) begin
      fc_nxt = (fc_q < WMAX_C) ? fc_q + 1'b1 : fc_q;
    end else begin
      // window shrank (or is full at the requested length)
      fc_nxt = FC_W'(wlen_q);
    end
  end

  assign rem_sh  = {rem_q, dvd_q[ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});

  // Handshakes
  assign smp_i.ready        = (state_q == wma_pkg::ST_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.mean_value   = out_mean_q;
  assign res_o.samples_used = out_used_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    fc_d        = fc_q;
    x_d         = x_q;
    used_d      = used_q;
    step_d      = step_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_used_d  = out_used_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = x_q;
    mem_re      = 1'b0;
    mem_ra      = '0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      wma_pkg::ST_IDLE: begin
        if (smp_i.valid) begin
          x_d    = smp_i.sample;
          step_d = '0;
          acc_d  = '0;
          if (smp_i.func == wma_pkg::FUNC_FILL) begin
            state_d = wma_pkg::ST_FILL;
          end else begin
            fc_d    = fc_nxt;
            used_d  = fc_nxt;
            state_d = wma_pkg::ST_SHIFT;
          end
        end
      end

      // one entry per cycle, count left alone
      wma_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = step_q;
        if (step_q == WMAX_C) begin
          mean_d  = x_q;
          used_d  = '0;
          state_d = wma_pkg::ST_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      // Read entry step+1 while writing the entry read last cycle one slot down
      wma_pkg::ST_SHIFT: begin
        if (step_q < used_q) begin
          mem_re = 1'b1;
          mem_ra = step_q + 1'b1;
        end
        if (step_q != '0) begin
          mem_we = 1'b1;
          mem_wa = step_q - 1'b1;
          mem_wd = rd_word;
          acc_d  = acc_q + ACC_W'($signed(rd_word));
        end
        if (step_q == used_q) begin
          state_d = wma_pkg::ST_PUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      // newest sample on top of the used part; weight product
      wma_pkg::ST_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = used_q;
        mem_wd  = x_q;
        prod_d  = ACC_W'(wgt_s) * ACC_W'(x_q);
        state_d = wma_pkg::ST_ADD;
      end

      wma_pkg::ST_ADD: begin
        acc_d   = acc_q + prod_q;
        dvs_d   = DVS_W'(used_q) + DVS_W'(wgt_q);
        state_d = wma_pkg::ST_PREP;
      end

      wma_pkg::ST_PREP: begin
        if (dvs_q == '0) begin
          // zero weight and empty window: echo the sample
          mean_d  = x_q;
          state_d = wma_pkg::ST_OUT;
        end else begin
          neg_d   = acc_q[ACC_W-1];
          dvd_d   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
          rem_d   = '0;
          cnt_d   = CNT_W'(ACC_W);
          state_d = wma_pkg::ST_DIV;
        end
      end

      // restoring divide, one quotient bit per cycle
      wma_pkg::ST_DIV: begin
        rem_d = qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        dvd_d = {dvd_q[ACC_W-2:0], qbit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = wma_pkg::ST_FIX;
        end
      end

      // truncate toward zero: divide magnitudes, then restore sign
      wma_pkg::ST_FIX: begin
        mean_d  = neg_q ? -$signed(dvd_q[DATA_W-1:0]) : $signed(dvd_q[DATA_W-1:0]);
        state_d = wma_pkg::ST_OUT;
      end

      wma_pkg::ST_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_mean_d  = mean_q;
          out_used_d  = wma_pkg::USED_W'(used_q);
          state_d     = wma_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wma_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wma_pkg::ST_IDLE;
      wlen_q      <= wma_pkg::WINDOW_LENGTH_RST;
      wgt_q       <= wma_pkg::NEWEST_WEIGHT_RST;
      fc_q        <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[mem_ra];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wma_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_data_i;
          wma_pkg::REG_NEWEST_WEIGHT: wgt_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    used_q     <= used_d;
    step_q     <= step_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    dvs_q      <= dvs_d;
    neg_q      <= neg_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    mean_q     <= mean_d;
    out_mean_q <= out_mean_d;
    out_used_q <= out_used_d;
  end

  // Window memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

`ifndef SYNTHESIS
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= WMAX_C)
    else $error("fill count above window maximum");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wma_pkg::ST_DIV) |-> (dvs_q != '0))
    else $error("divide with zero divisor");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_i.valid && smp_i.ready) |=>
      (state_q == wma_pkg::ST_FILL || state_q == wma_pkg::ST_SHIFT))
    else $error("accepted beat did not start work");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wma_pkg::ST_SHIFT) |-> (step_q <= used_q && used_q <= WMAX_C))
    else $error("shift walk out of range");
`endif

endmodule
